/* design/azab_pkg.sv */
package azab_pkg;

  // Signed Q1.14 value as carried between the units.
  typedef logic signed [15:0] q14_t;

  localparam q14_t        ONE_Q14  = 16'sd16384;
  localparam logic [15:0] ONE_MAG  = 16'd16384;

  // Quotient bits of the normalizing dividers and the scale applied
  // to a squared sum before its square root is taken.
  localparam int Q_W        = 16;
  localparam int NORM_SHIFT = 28;
  localparam int NORM_LAT   = Q_W + 2;

  // Root widths of the two square root units.
  localparam int AXIS_ROOT_W  = 30;
  localparam int CROSS_ROOT_W = 29;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH_SQ = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARALLEL_THR  = 1'b1;
  localparam logic [15:0] MIN_LENGTH_SQ_RST = 16'd1;
  localparam logic [14:0] PARALLEL_THR_RST  = 15'd16220;

  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
  } in_word_t;

  typedef struct packed {
    q14_t m00;
    q14_t m01;
    q14_t m02;
    q14_t m10;
    q14_t m11;
    q14_t m12;
    q14_t m20;
    q14_t m21;
    q14_t m22;
    logic degenerate;
  } out_word_t;

endpackage

/* design/align_z_to_axis_basis_core.sv */
// Orthonormal basis from an axis vector.
// A word on in_word (three signed Q8.8 components) is taken at every rising
// edge where start is high and busy is low; busy is high only while reset
// is applied and for the cycle after it, so a new word may follow every cycle.
// Each taken word yields one result word on out_word, flagged by out_valid for
// exactly one cycle. The result is a row-major 3x3 rotation in signed Q1.14
// whose third column is the unit axis, plus a degenerate flag that marks the
// identity answer. Throughput is one word per cycle. The datapath holds the
// two bit-serial square root pipelines (30 and 29 stages, one root bit per
// stage), the two normalizing divider pipelines (18 stages each: an input
// register, divide stages with one quotient bit per stage, and a saturating
// output register), and the registers for squaring, summing, axis selection,
// the final cross product and the output word.
// The receiver cannot hold results off, and none is needed: the pipeline never
// stalls. Synchronous reset clears all valid bits, so words in flight are
// dropped, and sets min_length_sq to 1 and parallel_threshold to 16220.
// Registers are written through cfg_we, cfg_index and cfg_wdata, by the user
// only while no word is in flight; the block itself does not enforce this.
module align_z_to_axis_basis_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  azab_pkg::in_word_t                  in_word,
  output logic                                out_valid,
  output azab_pkg::out_word_t                 out_word,
  input  logic                                cfg_we,
  input  logic [azab_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [azab_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int NSH = azab_pkg::NORM_SHIFT;
  localparam int AR  = azab_pkg::AXIS_ROOT_W;
  localparam int CR  = azab_pkg::CROSS_ROOT_W;
  localparam int LATENCY = 2 + AR + azab_pkg::NORM_LAT + 3 + CR
                           + azab_pkg::NORM_LAT + 2 + 1;

  // Tags that ride along the long arithmetic pipelines.
  typedef struct packed {
    azab_pkg::in_word_t axis;
    logic               degen;
  } ax_tag_t;

  typedef struct packed {
    azab_pkg::q14_t zx;
    azab_pkg::q14_t zy;
    azab_pkg::q14_t zz;
    azab_pkg::q14_t cx;
    azab_pkg::q14_t cy;
    azab_pkg::q14_t cz;
    logic           degen;
    logic           cs_zero;
  } cr_tag_t;

  typedef struct packed {
    azab_pkg::q14_t zx;
    azab_pkg::q14_t zy;
    azab_pkg::q14_t zz;
    logic           degen;
    logic           cs_zero;
  } nx_tag_t;

  typedef struct packed {
    azab_pkg::q14_t xx;
    azab_pkg::q14_t xy;
    azab_pkg::q14_t xz;
    azab_pkg::q14_t zx;
    azab_pkg::q14_t zy;
    azab_pkg::q14_t zz;
    logic           degen;
  } xy_tag_t;

  // Busy only around reset.
  logic busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  // Configuration registers.
  logic [15:0] min_len_sq_r;
  logic [14:0] par_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_sq_r <= azab_pkg::MIN_LENGTH_SQ_RST;
      par_thr_r    <= azab_pkg::PARALLEL_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        azab_pkg::CFG_MIN_LENGTH_SQ: min_len_sq_r <= cfg_wdata[15:0];
        azab_pkg::CFG_PARALLEL_THR:  par_thr_r    <= cfg_wdata[14:0];
        default:                     min_len_sq_r <= min_len_sq_r;
      endcase
    end
  end

  // Stage 1: square the axis components.
  logic               p1_vld_r;
  azab_pkg::in_word_t p1_axis_r;
  logic [30:0]        p1_sq_r [3];
  logic signed [31:0] ax_prod [3];

  always_comb begin
    ax_prod[0] = in_word.axis_x * in_word.axis_x;
    ax_prod[1] = in_word.axis_y * in_word.axis_y;
    ax_prod[2] = in_word.axis_z * in_word.axis_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= start && !busy_r;
    end
    p1_axis_r <= in_word;
    for (int i = 0; i < 3; i++) begin
      p1_sq_r[i] <= ax_prod[i][30:0];
    end
  end

  // Stage 2: squared length and the short axis test.
  logic        p2_vld_r;
  logic [31:0] p2_s_r;
  ax_tag_t     p2_tag_r;
  logic [31:0] s_nxt;

  assign s_nxt = 32'(p1_sq_r[0]) + 32'(p1_sq_r[1]) + 32'(p1_sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else begin
      p2_vld_r <= p1_vld_r;
    end
    p2_s_r         <= s_nxt;
    p2_tag_r.axis  <= p1_axis_r;
    p2_tag_r.degen <= (s_nxt == 32'd0) || (s_nxt < 32'(min_len_sq_r));
  end

  // Axis length.
  logic                      s1_vld;
  logic [AR-1:0]             s1_len;
  logic [$bits(ax_tag_t)-1:0] s1_tag_v;
  ax_tag_t                   s1_tag;

  azab_sqrt_pipe #(
    .ROOT_W (AR),
    .TAG_W  ($bits(ax_tag_t))
  ) u_sqrt_axis (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p2_vld_r),
    .in_rad    ({p2_s_r, {NSH{1'b0}}}),
    .in_tag    (p2_tag_r),
    .out_valid (s1_vld),
    .out_root  (s1_len),
    .out_tag   (s1_tag_v)
  );

  assign s1_tag = ax_tag_t'(s1_tag_v);

  // Unit axis.
  logic signed [15:0] n1_vec [3];
  logic               n1_vld;
  azab_pkg::q14_t     zn [3];
  logic [0:0]         n1_degen;

  assign n1_vec[0] = s1_tag.axis.axis_x;
  assign n1_vec[1] = s1_tag.axis.axis_y;
  assign n1_vec[2] = s1_tag.axis.axis_z;

  azab_norm_pipe #(
    .CW    (16),
    .LEN_W (AR),
    .TAG_W (1)
  ) u_norm_axis (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_vld),
    .in_vec    (n1_vec),
    .in_len    (s1_len),
    .in_tag    (s1_tag.degen),
    .out_valid (n1_vld),
    .out_vec   (zn),
    .out_tag   (n1_degen)
  );

  // Stage 3: pick the up vector and form cross(up, z).
  logic           p3_vld_r;
  logic           p3_degen_r;
  azab_pkg::q14_t p3_zn_r [3];
  azab_pkg::q14_t p3_c_r  [3];
  azab_pkg::q14_t c_nxt   [3];
  logic [15:0]    az;
  logic           use_y;

  always_comb begin
    az    = zn[2][15] ? 16'(-zn[2]) : 16'(zn[2]);
    use_y = (az > {1'b0, par_thr_r});
    if (use_y) begin
      c_nxt[0] = zn[2];
      c_nxt[1] = '0;
      c_nxt[2] = azab_pkg::q14_t'(-zn[0]);
    end else begin
      c_nxt[0] = azab_pkg::q14_t'(-zn[1]);
      c_nxt[1] = zn[0];
      c_nxt[2] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_vld_r <= 1'b0;
    end else begin
      p3_vld_r <= n1_vld;
    end
    p3_degen_r <= n1_degen[0];
    p3_zn_r    <= zn;
    p3_c_r     <= c_nxt;
  end

  // Stage 4: square the cross product.
  logic               p4_vld_r;
  logic               p4_degen_r;
  azab_pkg::q14_t     p4_zn_r [3];
  azab_pkg::q14_t     p4_c_r  [3];
  logic [28:0]        p4_sq_r [3];
  logic signed [31:0] c_prod  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_prod[i] = p3_c_r[i] * p3_c_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_vld_r <= 1'b0;
    end else begin
      p4_vld_r <= p3_vld_r;
    end
    p4_degen_r <= p3_degen_r;
    p4_zn_r    <= p3_zn_r;
    p4_c_r     <= p3_c_r;
    for (int i = 0; i < 3; i++) begin
      p4_sq_r[i] <= c_prod[i][28:0];
    end
  end

  // Stage 5: squared length of the cross product.
  logic        p5_vld_r;
  logic [29:0] p5_cs_r;
  cr_tag_t     p5_tag_r;
  logic [29:0] cs_nxt;

  assign cs_nxt = 30'(p4_sq_r[0]) + 30'(p4_sq_r[1]) + 30'(p4_sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p5_vld_r <= 1'b0;
    end else begin
      p5_vld_r <= p4_vld_r;
    end
    p5_cs_r          <= cs_nxt;
    p5_tag_r.zx      <= p4_zn_r[0];
    p5_tag_r.zy      <= p4_zn_r[1];
    p5_tag_r.zz      <= p4_zn_r[2];
    p5_tag_r.cx      <= p4_c_r[0];
    p5_tag_r.cy      <= p4_c_r[1];
    p5_tag_r.cz      <= p4_c_r[2];
    p5_tag_r.degen   <= p4_degen_r;
    p5_tag_r.cs_zero <= (cs_nxt == 30'd0);
  end

  // Length of the cross product.
  logic                       s2_vld;
  logic [CR-1:0]              s2_len;
  logic [$bits(cr_tag_t)-1:0] s2_tag_v;
  cr_tag_t                    s2_tag;

  azab_sqrt_pipe #(
    .ROOT_W (CR),
    .TAG_W  ($bits(cr_tag_t))
  ) u_sqrt_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p5_vld_r),
    .in_rad    ({p5_cs_r, {NSH{1'b0}}}),
    .in_tag    (p5_tag_r),
    .out_valid (s2_vld),
    .out_root  (s2_len),
    .out_tag   (s2_tag_v)
  );

  assign s2_tag = cr_tag_t'(s2_tag_v);

  // Unit x basis.
  logic signed [15:0]         n2_vec [3];
  nx_tag_t                    n2_in_tag;
  logic                       n2_vld;
  azab_pkg::q14_t             xr [3];
  logic [$bits(nx_tag_t)-1:0] n2_tag_v;
  nx_tag_t                    n2_tag;

  assign n2_vec[0] = s2_tag.cx;
  assign n2_vec[1] = s2_tag.cy;
  assign n2_vec[2] = s2_tag.cz;

  assign n2_in_tag.zx      = s2_tag.zx;
  assign n2_in_tag.zy      = s2_tag.zy;
  assign n2_in_tag.zz      = s2_tag.zz;
  assign n2_in_tag.degen   = s2_tag.degen;
  assign n2_in_tag.cs_zero = s2_tag.cs_zero;

  azab_norm_pipe #(
    .CW    (16),
    .LEN_W (CR),
    .TAG_W ($bits(nx_tag_t))
  ) u_norm_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_vld),
    .in_vec    (n2_vec),
    .in_len    (s2_len),
    .in_tag    (n2_in_tag),
    .out_valid (n2_vld),
    .out_vec   (xr),
    .out_tag   (n2_tag_v)
  );

  assign n2_tag = nx_tag_t'(n2_tag_v);

  // A vanishing cross product falls back to the +X direction.
  azab_pkg::q14_t xn  [3];
  azab_pkg::q14_t zn2 [3];
  xy_tag_t        cy_in_tag;

  assign xn[0]  = n2_tag.cs_zero ? azab_pkg::ONE_Q14 : xr[0];
  assign xn[1]  = n2_tag.cs_zero ? '0 : xr[1];
  assign xn[2]  = n2_tag.cs_zero ? '0 : xr[2];
  assign zn2[0] = n2_tag.zx;
  assign zn2[1] = n2_tag.zy;
  assign zn2[2] = n2_tag.zz;

  assign cy_in_tag.xx    = xn[0];
  assign cy_in_tag.xy    = xn[1];
  assign cy_in_tag.xz    = xn[2];
  assign cy_in_tag.zx    = zn2[0];
  assign cy_in_tag.zy    = zn2[1];
  assign cy_in_tag.zz    = zn2[2];
  assign cy_in_tag.degen = n2_tag.degen;

  // y basis as cross(z, x).
  logic                       cy_vld;
  azab_pkg::q14_t             yn [3];
  logic [$bits(xy_tag_t)-1:0] cy_tag_v;
  xy_tag_t                    cy_tag;

  azab_cross_y #(
    .TAG_W ($bits(xy_tag_t))
  ) u_cross_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (n2_vld),
    .in_z      (zn2),
    .in_x      (xn),
    .in_tag    (cy_in_tag),
    .out_valid (cy_vld),
    .out_y     (yn),
    .out_tag   (cy_tag_v)
  );

  assign cy_tag = xy_tag_t'(cy_tag_v);

  // Output register: assemble the matrix, or the identity for a short axis.
  logic                out_vld_r;
  azab_pkg::out_word_t out_word_r;
  azab_pkg::out_word_t out_nxt;

  always_comb begin
    if (cy_tag.degen) begin
      out_nxt     = '0;
      out_nxt.m00 = azab_pkg::ONE_Q14;
      out_nxt.m11 = azab_pkg::ONE_Q14;
      out_nxt.m22 = azab_pkg::ONE_Q14;
      out_nxt.degenerate = 1'b1;
    end else begin
      out_nxt.m00 = cy_tag.xx;
      out_nxt.m01 = yn[0];
      out_nxt.m02 = cy_tag.zx;
      out_nxt.m10 = cy_tag.xy;
      out_nxt.m11 = yn[1];
      out_nxt.m12 = cy_tag.zy;
      out_nxt.m20 = cy_tag.xz;
      out_nxt.m21 = yn[2];
      out_nxt.m22 = cy_tag.zz;
      out_nxt.degenerate = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= cy_vld;
    end
    out_word_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_word  = out_word_r;

  // Every result traces back to a word taken exactly one pipeline depth earlier.
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without a matching input word");

  // Saturation in the dividers and the cross product keeps the diagonal in range.
  a_diag_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.m00 <= azab_pkg::ONE_Q14) && (out_word.m00 >= -azab_pkg::ONE_Q14)
               && (out_word.m11 <= azab_pkg::ONE_Q14) && (out_word.m11 >= -azab_pkg::ONE_Q14)
               && (out_word.m22 <= azab_pkg::ONE_Q14) && (out_word.m22 >= -azab_pkg::ONE_Q14))
    else $error("matrix diagonal outside plus or minus one");

endmodule

/* design/azab_sqrt_pipe.sv */
module azab_sqrt_pipe #(
  parameter int ROOT_W = 30,
  parameter int TAG_W  = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [2*ROOT_W-1:0] in_rad,
  input  logic [TAG_W-1:0]    in_tag,
  output logic                out_valid,
  output logic [ROOT_W-1:0]   out_root,
  output logic [TAG_W-1:0]    out_tag
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  // One root bit per stage, two radicand bits brought down each time.
  logic [ROOT_W-1:0] vld_r;
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [RAD_W-1:0]  rad_r  [ROOT_W];
  logic [TAG_W-1:0]  tag_r  [ROOT_W];

  logic [ROOT_W-1:0] stg_vld;
  logic [REM_W-1:0]  stg_rem  [ROOT_W];
  logic [ROOT_W-1:0] stg_root [ROOT_W];
  logic [RAD_W-1:0]  stg_rad  [ROOT_W];
  logic [TAG_W-1:0]  stg_tag  [ROOT_W];

  logic [REM_W-1:0]  rem_nxt  [ROOT_W];
  logic [ROOT_W-1:0] root_nxt [ROOT_W];
  logic [RAD_W-1:0]  rad_nxt  [ROOT_W];

  always_comb begin
    stg_vld[0]  = in_valid;
    stg_rem[0]  = '0;
    stg_root[0] = '0;
    stg_rad[0]  = in_rad;
    stg_tag[0]  = in_tag;
    for (int k = 1; k < ROOT_W; k++) begin
      stg_vld[k]  = vld_r[k-1];
      stg_rem[k]  = rem_r[k-1];
      stg_root[k] = root_r[k-1];
      stg_rad[k]  = rad_r[k-1];
      stg_tag[k]  = tag_r[k-1];
    end
  end

  always_comb begin
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;
    for (int k = 0; k < ROOT_W; k++) begin
      rem_sh = {stg_rem[k][REM_W-3:0], stg_rad[k][RAD_W-1 -: 2]};
      trial  = {stg_root[k], 2'b01};
      ge     = (rem_sh >= trial);
      rem_nxt[k]  = ge ? (rem_sh - trial) : rem_sh;
      root_nxt[k] = {stg_root[k][ROOT_W-2:0], ge};
      rad_nxt[k]  = {stg_rad[k][RAD_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= stg_vld;
    end
    for (int k = 0; k < ROOT_W; k++) begin
      rem_r[k]  <= rem_nxt[k];
      root_r[k] <= root_nxt[k];
      rad_r[k]  <= rad_nxt[k];
      tag_r[k]  <= stg_tag[k];
    end
  end

  assign out_valid = vld_r[ROOT_W-1];
  assign out_root  = root_r[ROOT_W-1];
  assign out_tag   = tag_r[ROOT_W-1];

endmodule

/* design/azab_norm_pipe.sv */
module azab_norm_pipe #(
  parameter int CW    = 16,
  parameter int LEN_W = 30,
  parameter int TAG_W = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic signed [CW-1:0] in_vec [3],
  input  logic [LEN_W-1:0]    in_len,
  input  logic [TAG_W-1:0]    in_tag,
  output logic                out_valid,
  output azab_pkg::q14_t      out_vec [3],
  output logic [TAG_W-1:0]    out_tag
);

  localparam int QW    = azab_pkg::Q_W;
  localparam int NUM_W = CW + azab_pkg::NORM_SHIFT + 2;
  localparam int DEN_W = LEN_W + 1;
  localparam int REM_W = LEN_W + 2;

  // Each lane computes round(|v| * 2^28 / len) as
  // floor((|v| * 2^29 + len) / (2 * len)), one quotient bit per stage.
  logic [CW-1:0]    mag [3];
  logic [NUM_W-1:0] num [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = in_vec[i][CW-1] ? CW'(-in_vec[i]) : CW'(in_vec[i]);
      num[i] = (NUM_W'(mag[i]) << (azab_pkg::NORM_SHIFT + 1)) + NUM_W'(in_len);
    end
  end

  logic             p_vld_r;
  logic [REM_W-1:0] p_rem_r [3];
  logic [QW-1:0]    p_low_r [3];
  logic             p_neg_r [3];
  logic [DEN_W-1:0] p_den_r;
  logic [TAG_W-1:0] p_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= in_valid;
    end
    for (int i = 0; i < 3; i++) begin
      p_rem_r[i] <= REM_W'(num[i][NUM_W-1:QW]);
      p_low_r[i] <= num[i][QW-1:0];
      p_neg_r[i] <= in_vec[i][CW-1];
    end
    p_den_r <= {in_len, 1'b0};
    p_tag_r <= in_tag;
  end

  logic [QW-1:0]    vld_r;
  logic [REM_W-1:0] rem_r [QW][3];
  logic [QW-1:0]    low_r [QW][3];
  logic [QW-1:0]    q_r   [QW][3];
  logic             neg_r [QW][3];
  logic [DEN_W-1:0] den_r [QW];
  logic [TAG_W-1:0] tag_r [QW];

  logic [QW-1:0]    stg_vld;
  logic [REM_W-1:0] stg_rem [QW][3];
  logic [QW-1:0]    stg_low [QW][3];
  logic [QW-1:0]    stg_q   [QW][3];
  logic             stg_neg [QW][3];
  logic [DEN_W-1:0] stg_den [QW];
  logic [TAG_W-1:0] stg_tag [QW];

  logic [REM_W-1:0] rem_nxt [QW][3];
  logic [QW-1:0]    low_nxt [QW][3];
  logic [QW-1:0]    q_nxt   [QW][3];

  always_comb begin
    stg_vld[0] = p_vld_r;
    stg_den[0] = p_den_r;
    stg_tag[0] = p_tag_r;
    for (int i = 0; i < 3; i++) begin
      stg_rem[0][i] = p_rem_r[i];
      stg_low[0][i] = p_low_r[i];
      stg_q[0][i]   = '0;
      stg_neg[0][i] = p_neg_r[i];
    end
    for (int k = 1; k < QW; k++) begin
      stg_vld[k] = vld_r[k-1];
      stg_den[k] = den_r[k-1];
      stg_tag[k] = tag_r[k-1];
      for (int i = 0; i < 3; i++) begin
        stg_rem[k][i] = rem_r[k-1][i];
        stg_low[k][i] = low_r[k-1][i];
        stg_q[k][i]   = q_r[k-1][i];
        stg_neg[k][i] = neg_r[k-1][i];
      end
    end
  end

  always_comb begin
    logic [REM_W-1:0] r2;
    logic [REM_W-1:0] den;
    logic             ge;
    for (int k = 0; k < QW; k++) begin
      den = REM_W'(stg_den[k]);
      for (int i = 0; i < 3; i++) begin
        r2 = {stg_rem[k][i][REM_W-2:0], stg_low[k][i][QW-1]};
        ge = (r2 >= den);
        rem_nxt[k][i] = ge ? (r2 - den) : r2;
        low_nxt[k][i] = {stg_low[k][i][QW-2:0], 1'b0};
        q_nxt[k][i]   = {stg_q[k][i][QW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= stg_vld;
    end
    for (int k = 0; k < QW; k++) begin
      den_r[k] <= stg_den[k];
      tag_r[k] <= stg_tag[k];
      for (int i = 0; i < 3; i++) begin
        rem_r[k][i] <= rem_nxt[k][i];
        low_r[k][i] <= low_nxt[k][i];
        q_r[k][i]   <= q_nxt[k][i];
        neg_r[k][i] <= stg_neg[k][i];
      end
    end
  end

  // Saturate to one and put the sign back.
  logic                 o_vld_r;
  azab_pkg::q14_t       o_vec_r   [3];
  logic [TAG_W-1:0]     o_tag_r;
  azab_pkg::q14_t       o_vec_nxt [3];

  always_comb begin
    logic [QW-1:0] qs;
    for (int i = 0; i < 3; i++) begin
      qs = (q_r[QW-1][i] > QW'(azab_pkg::ONE_MAG)) ? QW'(azab_pkg::ONE_MAG)
                                                    : q_r[QW-1][i];
      o_vec_nxt[i] = neg_r[QW-1][i] ? azab_pkg::q14_t'(16'(-qs))
                                    : azab_pkg::q14_t'(16'(qs));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else begin
      o_vld_r <= vld_r[QW-1];
    end
    for (int i = 0; i < 3; i++) begin
      o_vec_r[i] <= o_vec_nxt[i];
    end
    o_tag_r <= tag_r[QW-1];
  end

  assign out_valid = o_vld_r;
  assign out_vec   = o_vec_r;
  assign out_tag   = o_tag_r;

endmodule

/* design/azab_cross_y.sv */
module azab_cross_y #(
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  azab_pkg::q14_t   in_z [3],
  input  azab_pkg::q14_t   in_x [3],
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output azab_pkg::q14_t   out_y [3],
  output logic [TAG_W-1:0] out_tag
);

  // Products in Q2.28, one register stage, then difference, rounding and
  // saturation in the second.
  logic               p_vld_r;
  logic signed [31:0] prod_r   [6];
  logic signed [31:0] prod_nxt [6];
  logic [TAG_W-1:0]   p_tag_r;

  always_comb begin
    prod_nxt[0] = in_z[1] * in_x[2];
    prod_nxt[1] = in_z[2] * in_x[1];
    prod_nxt[2] = in_z[2] * in_x[0];
    prod_nxt[3] = in_z[0] * in_x[2];
    prod_nxt[4] = in_z[0] * in_x[1];
    prod_nxt[5] = in_z[1] * in_x[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= in_valid;
    end
    prod_r  <= prod_nxt;
    p_tag_r <= in_tag;
  end

  logic             y_vld_r;
  azab_pkg::q14_t   y_r   [3];
  azab_pkg::q14_t   y_nxt [3];
  logic [TAG_W-1:0] y_tag_r;

  always_comb begin
    logic signed [32:0] diff;
    logic [32:0]        mag;
    logic [32:0]        rnd;
    logic [18:0]        rq;
    logic [15:0]        sat_m;
    for (int j = 0; j < 3; j++) begin
      diff  = 33'(prod_r[2*j]) - 33'(prod_r[2*j+1]);
      mag   = diff[32] ? 33'(-diff) : 33'(diff);
      rnd   = mag + 33'd8192;
      rq    = rnd[32:14];
      sat_m = (rq > 19'(azab_pkg::ONE_MAG)) ? azab_pkg::ONE_MAG : rq[15:0];
      y_nxt[j] = diff[32] ? azab_pkg::q14_t'(-sat_m) : azab_pkg::q14_t'(sat_m);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_vld_r <= 1'b0;
    end else begin
      y_vld_r <= p_vld_r;
    end
    y_r     <= y_nxt;
    y_tag_r <= p_tag_r;
  end

  assign out_valid = y_vld_r;
  assign out_y     = y_r;
  assign out_tag   = y_tag_r;

endmodule
